@@ hdl/fcpt_pkg.sv @@
// Shared types, constants and the quarter-wave sine builder for the FOC transform unit.
package fcpt_pkg;

    localparam int unsigned SINE_ADDR_BITS_DEF = 10;
    localparam int unsigned SINE_ADDR_BITS_MIN = 6;
    localparam int unsigned SINE_ADDR_BITS_MAX = 14;

    localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q_MIN = -16'sh8000;

    // sqrt(3)/2 in Q0.16
    localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;

    // odd polynomial coefficients of sin(pi/2 * x), Q30
    localparam longint unsigned C1_Q30 = 64'd1686629713;
    localparam longint unsigned C3_Q30 = 64'd693598668;
    localparam longint unsigned C5_Q30 = 64'd85569306;
    localparam longint unsigned C7_Q30 = 64'd5026995;
    localparam longint unsigned C9_Q30 = 64'd172272;

    typedef enum logic [1:0] {
        CMD_CLARKE = 2'd0,
        CMD_PARK   = 2'd1,
        CMD_IPARK  = 2'd2,
        CMD_SECTOR = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] sector;
    } t_item_ctl;

    // Quarter-wave entry k of 2^b steps, Q1.15; only ever called with constant arguments.
    function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned b);
        longint unsigned n;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        n = 64'd1 << b;
        if (64'(k) >= n) begin
            return 15'h7FFF;
        end
        x  = 64'(k) << (30 - b);
        x2 = (x * x) >> 30;
        t  = C9_Q30;
        t  = C7_Q30 - ((x2 * t) >> 30);
        t  = C5_Q30 - ((x2 * t) >> 30);
        t  = C3_Q30 - ((x2 * t) >> 30);
        t  = C1_Q30 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[14:0];
    endfunction

endpackage

@@ hdl/fcpt_sine_lookup.sv @@
// Quarter-wave sine/cosine lookup with registered outputs.
module fcpt_sine_lookup #(
    parameter int unsigned ADDR_BITS = fcpt_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);
    import fcpt_pkg::*;

    localparam int unsigned N = 1 << ADDR_BITS;
    localparam logic [ADDR_BITS:0] N_IDX = (ADDR_BITS + 1)'(N);

    logic [14:0]          w_rom [0:N];
    logic [15:0]          w_cos_angle;
    logic [ADDR_BITS:0]   w_sin_idx;
    logic [ADDR_BITS:0]   w_cos_idx;
    logic signed [15:0]   n_sin;
    logic signed [15:0]   n_cos;
    logic signed [15:0]   r_sin;
    logic signed [15:0]   r_cos;

    for (genvar gk = 0; gk <= N; gk++) begin : g_rom
        assign w_rom[gk] = quarter_sine(gk, ADDR_BITS);
    end

    // cos(angle) = sin(angle + quarter turn), wrapping at one turn
    assign w_cos_angle = i_angle + 16'h4000;

    // odd quadrants run the table backwards
    assign w_sin_idx = i_angle[14] ? (N_IDX - {1'b0, i_angle[13 -: ADDR_BITS]})
                                   : {1'b0, i_angle[13 -: ADDR_BITS]};
    assign w_cos_idx = w_cos_angle[14] ? (N_IDX - {1'b0, w_cos_angle[13 -: ADDR_BITS]})
                                       : {1'b0, w_cos_angle[13 -: ADDR_BITS]};

    always_comb begin
        n_sin = signed'({1'b0, w_rom[w_sin_idx]});
        n_cos = signed'({1'b0, w_rom[w_cos_idx]});
        if (i_angle[15]) begin
            n_sin = -n_sin;
        end
        if (w_cos_angle[15]) begin
            n_cos = -n_cos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

@@ hdl/fcpt_product_stage.sv @@
// Product stage: rotation and Clarke products, Clarke sum and sector number.
module fcpt_product_stage (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  fcpt_pkg::t_cmd        i_cmd,
    input  logic signed [15:0]    i_a,
    input  logic signed [15:0]    i_b,
    input  logic signed [15:0]    i_c,
    input  logic [15:0]           i_angle,
    input  logic signed [15:0]    i_sin,
    input  logic signed [15:0]    i_cos,
    output fcpt_pkg::t_item_ctl   o_ctl,
    output logic signed [31:0]    o_acos,
    output logic signed [31:0]    o_bsin,
    output logic signed [31:0]    o_bcos,
    output logic signed [31:0]    o_asin,
    output logic signed [33:0]    o_clarke_prod,
    output logic signed [18:0]    o_clarke_sum
);
    import fcpt_pkg::*;

    logic signed [16:0] w_diff;
    logic signed [34:0] w_kprod;
    logic [18:0]        w_ang6;
    t_item_ctl          n_ctl;

    t_item_ctl          r_ctl;
    logic signed [31:0] r_acos;
    logic signed [31:0] r_bsin;
    logic signed [31:0] r_bcos;
    logic signed [31:0] r_asin;
    logic signed [33:0] r_clarke_prod;
    logic signed [18:0] r_clarke_sum;

    assign w_diff  = 17'(i_b) - 17'(i_c);
    assign w_kprod = 35'(w_diff) * 35'(signed'({1'b0, SQRT3_HALF_Q16}));

    // angle * 6 as shift-and-add; top bits give the sixty-degree sector
    assign w_ang6 = {1'b0, i_angle, 2'b00} + {2'b00, i_angle, 1'b0};

    always_comb begin
        n_ctl.cmd    = i_cmd;
        n_ctl.sector = (i_cmd == CMD_SECTOR) ? (w_ang6[18:16] + 3'd1) : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl         <= n_ctl;
            r_acos        <= i_a * i_cos;
            r_bsin        <= i_b * i_sin;
            r_bcos        <= i_b * i_cos;
            r_asin        <= i_a * i_sin;
            r_clarke_prod <= w_kprod[33:0];
            r_clarke_sum  <= 19'(i_a) + 19'(i_a) - 19'(i_b) - 19'(i_c);
        end
    end

    assign o_ctl         = r_ctl;
    assign o_acos        = r_acos;
    assign o_bsin        = r_bsin;
    assign o_bcos        = r_bcos;
    assign o_asin        = r_asin;
    assign o_clarke_prod = r_clarke_prod;
    assign o_clarke_sum  = r_clarke_sum;

endmodule

@@ hdl/fcpt_result_stage.sv @@
// Result stage: combine products, round half up, saturate to Q1.15.
module fcpt_result_stage (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  fcpt_pkg::t_item_ctl   i_ctl,
    input  logic signed [31:0]    i_acos,
    input  logic signed [31:0]    i_bsin,
    input  logic signed [31:0]    i_bcos,
    input  logic signed [31:0]    i_asin,
    input  logic signed [33:0]    i_clarke_prod,
    input  logic signed [18:0]    i_clarke_sum,
    output logic signed [15:0]    o_x,
    output logic signed [15:0]    o_y,
    output logic [2:0]            o_sector,
    output logic                  o_saturated
);
    import fcpt_pkg::*;

    logic signed [34:0] w_xf;
    logic signed [34:0] w_yf;
    logic signed [15:0] n_x;
    logic signed [15:0] n_y;
    logic               n_sat;

    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [2:0]         r_sector;
    logic               r_sat;

    always_comb begin
        case (i_ctl.cmd)
            CMD_CLARKE: begin
                w_xf = (35'(i_clarke_sum) + 35'sd1) >>> 1;
                w_yf = (35'(i_clarke_prod) + 35'sd32768) >>> 16;
            end
            CMD_PARK: begin
                w_xf = (35'(i_acos) + 35'(i_bsin) + 35'sd16384) >>> 15;
                w_yf = (35'(i_bcos) - 35'(i_asin) + 35'sd16384) >>> 15;
            end
            CMD_IPARK: begin
                w_xf = (35'(i_acos) - 35'(i_bsin) + 35'sd16384) >>> 15;
                w_yf = (35'(i_bcos) + 35'(i_asin) + 35'sd16384) >>> 15;
            end
            default: begin
                w_xf = '0;
                w_yf = '0;
            end
        endcase

        n_sat = 1'b0;
        if (w_xf > 35'(Q_MAX)) begin
            n_x   = Q_MAX;
            n_sat = 1'b1;
        end else if (w_xf < 35'(Q_MIN)) begin
            n_x   = Q_MIN;
            n_sat = 1'b1;
        end else begin
            n_x = w_xf[15:0];
        end
        if (w_yf > 35'(Q_MAX)) begin
            n_y   = Q_MAX;
            n_sat = 1'b1;
        end else if (w_yf < 35'(Q_MIN)) begin
            n_y   = Q_MIN;
            n_sat = 1'b1;
        end else begin
            n_y = w_yf[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_sector <= i_ctl.sector;
            r_sat    <= n_sat;
        end
    end

    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_sector    = r_sector;
    assign o_saturated = r_sat;

endmodule

@@ hdl/foc_clarke_park_transform_unit.sv @@
// Top level of the FOC Clarke / Park / inverse Park transform unit.
//
// Takes one word per clock unless stalled; one result per input word, in order.
// Commands: Clarke (a, b, c to alpha/beta), Park rotation by -angle, inverse Park
// rotation by +angle, and sector (1..6 of the angle; x and y read zero then).
// All values are signed Q1.15; results are rounded half up and saturated, and
// o_saturated flags a clip on either output. The angle is an unsigned fraction
// of a turn; sine and cosine come from a quarter-wave table with
// 2^SINE_TABLE_ADDR_BITS + 1 entries, so the angle bits below the table index
// are dropped. Throughput is one word per cycle while i_ready does not stall
// the output. There are three register stages: input plus table read, the four
// 16x16 products, and round / saturate into the output register. o_valid rises
// once an accepted word reaches the output register. Back-pressure on i_ready
// stalls the pipe stage by stage, so bubbles are squeezed out and the input side
// keeps moving while the output word waits as long as an earlier stage is empty;
// with all three stages full, o_ready follows i_ready in the same cycle.
module foc_clarke_park_transform_unit #(
    parameter int unsigned SINE_TABLE_ADDR_BITS = fcpt_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic signed [15:0] i_in_a,
    input  logic signed [15:0] i_in_b,
    input  logic signed [15:0] i_in_c,
    input  logic [15:0]        i_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic [2:0]         o_sector,
    output logic               o_saturated
);
    import fcpt_pkg::*;

    // stage valids: input/table, products, output
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;

    // a stage takes a new word when empty or when its word moves on
    logic w_s3_ready;
    logic w_s2_ready;
    logic w_s1_ready;

    // input register
    t_cmd               r_s1_cmd;
    logic signed [15:0] r_s1_a;
    logic signed [15:0] r_s1_b;
    logic signed [15:0] r_s1_c;
    logic [15:0]        r_s1_angle;

    logic signed [15:0] w_sin;
    logic signed [15:0] w_cos;

    t_item_ctl          w_s2_ctl;
    logic signed [31:0] w_acos;
    logic signed [31:0] w_bsin;
    logic signed [31:0] w_bcos;
    logic signed [31:0] w_asin;
    logic signed [33:0] w_clarke_prod;
    logic signed [18:0] w_clarke_sum;

    assign w_s3_ready = !r_s3_valid || i_ready;
    assign w_s2_ready = !r_s2_valid || w_s3_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_s1_cmd   <= t_cmd'(i_command);
            r_s1_a     <= i_in_a;
            r_s1_b     <= i_in_b;
            r_s1_c     <= i_in_c;
            r_s1_angle <= i_angle;
        end
    end

    // table read is registered alongside the input word
    fcpt_sine_lookup #(
        .ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_en    (w_s1_ready),
        .i_angle (i_angle),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    fcpt_product_stage u_prod (
        .i_clk         (i_clk),
        .i_en          (w_s2_ready),
        .i_cmd         (r_s1_cmd),
        .i_a           (r_s1_a),
        .i_b           (r_s1_b),
        .i_c           (r_s1_c),
        .i_angle       (r_s1_angle),
        .i_sin         (w_sin),
        .i_cos         (w_cos),
        .o_ctl         (w_s2_ctl),
        .o_acos        (w_acos),
        .o_bsin        (w_bsin),
        .o_bcos        (w_bcos),
        .o_asin        (w_asin),
        .o_clarke_prod (w_clarke_prod),
        .o_clarke_sum  (w_clarke_sum)
    );

    fcpt_result_stage u_result (
        .i_clk         (i_clk),
        .i_en          (w_s3_ready),
        .i_ctl         (w_s2_ctl),
        .i_acos        (w_acos),
        .i_bsin        (w_bsin),
        .i_bcos        (w_bcos),
        .i_asin        (w_asin),
        .i_clarke_prod (w_clarke_prod),
        .i_clarke_sum  (w_clarke_sum),
        .o_x           (o_out_x),
        .o_y           (o_out_y),
        .o_sector      (o_sector),
        .o_saturated   (o_saturated)
    );

    assign o_ready = w_s1_ready;
    assign o_valid = r_s3_valid;

endmodule

@@ hdl/fcpt_checker.sv @@
// Port-level checks for the FOC transform unit, bound to the top level.
module fcpt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_ready,
    input logic               o_valid,
    input logic signed [15:0] o_out_x,
    input logic signed [15:0] o_out_y,
    input logic [2:0]         o_sector,
    input logic               o_saturated
);
    import fcpt_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_sector) && $stable(o_saturated))
        else $error("result word changed while stalled");

    // no result word straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // sector words carry zero outputs and no clip
    a_sector_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sector != 3'd0 |-> o_out_x == 16'sd0 && o_out_y == 16'sd0
            && !o_saturated)
        else $error("sector word with non-zero payload");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sector <= 3'd6)
        else $error("sector out of range");

    // a clip leaves at least one output at a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_out_x == Q_MAX || o_out_x == Q_MIN
            || o_out_y == Q_MAX || o_out_y == Q_MIN)
        else $error("saturated flag without a rail value");

endmodule

bind foc_clarke_park_transform_unit fcpt_checker u_fcpt_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the FOC Clarke / Park / inverse Park transform unit.
module tb_top;

    import fcpt_pkg::t_cmd;
    import fcpt_pkg::CMD_CLARKE;
    import fcpt_pkg::CMD_PARK;
    import fcpt_pkg::CMD_IPARK;
    import fcpt_pkg::CMD_SECTOR;

    // Table depth the block is built with (default parameter).
    localparam int unsigned LUT_BITS = fcpt_pkg::SINE_ADDR_BITS_DEF;

    // Timeout for the whole run; keep a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 600;
    localparam int HOLD_OFF_AT = 250;      // accepted words before the long receiver hold-off
    localparam int HOLD_OFF_LEN = 150;

    // sqrt(3)/2 in Q0.16 and the sine polynomial coefficients in Q30.
    localparam longint SQRT3_HALF = 56756;
    localparam longint unsigned POLY_C1 = 64'd1686629713;
    localparam longint unsigned POLY_C3 = 64'd693598668;
    localparam longint unsigned POLY_C5 = 64'd85569306;
    localparam longint unsigned POLY_C7 = 64'd5026995;
    localparam longint unsigned POLY_C9 = 64'd172272;

    // One input word, plus a flag that makes the sender wait for an empty pipe first.
    typedef struct {
        t_cmd               cmd;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic [15:0]        ang;
        bit                 drain;
    } xform_word_t;

    // One predicted result word; cmd is kept only for the run summary.
    typedef struct {
        t_cmd               cmd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [2:0]         sector;
        logic               sat;
    } xform_result_t;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_command = CMD_CLARKE;
    logic signed [15:0] i_in_a = '0;
    logic signed [15:0] i_in_b = '0;
    logic signed [15:0] i_in_c = '0;
    logic [15:0]        i_angle = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic [2:0]         o_sector;
    logic               o_saturated;

    xform_word_t   pending_words[$];
    xform_result_t expected_results[$];

    bit word_taken = 1'b0;        // set at the rising edge, read by the driver at the falling edge
    int cycle_count = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int fail_count = 0;
    int per_cmd[4] = '{0, 0, 0, 0};
    int sat_seen = 0;

    foc_clarke_park_transform_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_in_a      (i_in_a),
        .i_in_b      (i_in_b),
        .i_in_c      (i_in_c),
        .i_angle     (i_angle),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_sector    (o_sector),
        .o_saturated (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Quarter-wave entry k, Q1.15: odd degree-9 polynomial in Q30, truncating products.
    function automatic longint quarter_wave(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        if (k >= (64'd1 << LUT_BITS)) begin
            return 32767;
        end
        x  = k << (30 - LUT_BITS);
        x2 = (x * x) >> 30;
        t  = POLY_C9;
        t  = POLY_C7 - ((x2 * t) >> 30);
        t  = POLY_C5 - ((x2 * t) >> 30);
        t  = POLY_C3 - ((x2 * t) >> 30);
        t  = POLY_C1 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return longint'(s);
    endfunction

    // Top two angle bits give the quadrant, the next LUT_BITS the index; the rest are dropped.
    function automatic longint sine_q15(input logic [15:0] ang);
        longint unsigned idx;
        longint v;
        idx = longint'(ang[13:0]) >> (14 - LUT_BITS);
        v = ang[14] ? quarter_wave((64'd1 << LUT_BITS) - idx) : quarter_wave(idx);
        return ang[15] ? -v : v;
    endfunction

    // Round half towards plus infinity: add half, then floor.
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clip_q15(input longint v, output bit clipped);
        clipped = 1'b0;
        if (v > 32767) begin
            clipped = 1'b1;
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            clipped = 1'b1;
            return -16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic xform_result_t predict_transform(input xform_word_t w);
        xform_result_t r;
        longint a;
        longint b;
        longint c;
        longint sn;
        longint cs;
        longint vx;
        longint vy;
        bit cx;
        bit cy;
        a = w.a;
        b = w.b;
        c = w.c;
        vx = 0;
        vy = 0;
        r.cmd = w.cmd;
        r.sector = 3'd0;
        sn = sine_q15(w.ang);
        cs = sine_q15(w.ang + 16'd16384);
        case (w.cmd)
            CMD_CLARKE: begin
                vx = round_half_up(2 * a - b - c, 1);
                vy = round_half_up((b - c) * SQRT3_HALF, 16);
            end
            CMD_PARK: begin
                vx = round_half_up(a * cs + b * sn, 15);
                vy = round_half_up(b * cs - a * sn, 15);
            end
            CMD_IPARK: begin
                vx = round_half_up(a * cs - b * sn, 15);
                vy = round_half_up(b * cs + a * sn, 15);
            end
            default: begin
                r.sector = 3'(1 + ((longint'(w.ang) * 6) >> 16));
            end
        endcase
        r.x = clip_q15(vx, cx);
        r.y = clip_q15(vy, cy);
        r.sat = cx | cy;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_word(input t_cmd cmd, input int a, input int b, input int c,
                                       input int ang, input bit drain);
        xform_word_t w;
        w.cmd   = cmd;
        w.a     = 16'(a);
        w.b     = 16'(b);
        w.c     = 16'(c);
        w.ang   = 16'(ang);
        w.drain = drain;
        pending_words.push_back(w);
    endfunction

    // Mostly full-range values, with a good share of the extremes and values near zero.
    function automatic int pick_q15();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return int'($urandom_range(0, 2000)) - 1000;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Angles near quadrant and sector boundaries turn up often; the rest are uniform.
    function automatic int pick_angle();
        int base;
        case ($urandom_range(0, 5))
            0: begin
                base = 16384 * int'($urandom_range(0, 4));
                return (base + int'($urandom_range(0, 64)) - 32) & 16'hFFFF;
            end
            1: begin
                base = (65536 * int'($urandom_range(0, 6))) / 6;
                return (base + int'($urandom_range(0, 8)) - 4) & 16'hFFFF;
            end
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length with random gaps, fed from pending_words.
    // A word flagged drain is held back until every outstanding result is in.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin : driver
        xform_word_t w;
        if (i_rst_n && (!i_valid || word_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain && expected_results.size() != 0)) begin
                w = pending_words.pop_front();
                i_valid   <= 1'b1;
                i_command <= w.cmd;
                i_in_a    <= w.a;
                i_in_b    <= w.b;
                i_in_c    <= w.c;
                i_angle   <= w.ang;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switches among stall modes (free running,
    // coin toss, mostly stalled), plus one long hold-off mid-run so the
    // pipe fills and o_ready drops while the driver keeps offering words.
    // ------------------------------------------------------------------
    int ready_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge i_clk) begin : receiver
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && words_accepted >= HOLD_OFF_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_LEN - 1;
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (ready_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 1) == 1);
                default: i_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge. Results are checked
    // against the oldest expectation; accepted words are predicted and queued.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        xform_word_t w;
        xform_result_t e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end else begin
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: x=%0d y=%0d sector=%0d sat=%0b",
                           o_out_x, o_out_y, o_sector, o_saturated);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_out_x !== e.x) begin
                        $error("out_x mismatch: expected %0d, got %0d", e.x, o_out_x);
                        fail_count++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y mismatch: expected %0d, got %0d", e.y, o_out_y);
                        fail_count++;
                    end
                    if (o_sector !== e.sector) begin
                        $error("sector mismatch: expected %0d, got %0d", e.sector, o_sector);
                        fail_count++;
                    end
                    if (o_saturated !== e.sat) begin
                        $error("saturated mismatch: expected %0b, got %0b", e.sat, o_saturated);
                        fail_count++;
                    end
                    results_checked++;
                    per_cmd[e.cmd]++;
                    if (e.sat) begin
                        sat_seen++;
                    end
                end
            end
            word_taken = i_rst_n && i_valid && o_ready;
            if (word_taken) begin
                w.cmd   = t_cmd'(i_command);
                w.a     = i_in_a;
                w.b     = i_in_b;
                w.c     = i_in_c;
                w.ang   = i_angle;
                w.drain = 1'b0;
                expected_results.push_back(predict_transform(w));
                words_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed words, then random ones, then wait for the tail.
    // ------------------------------------------------------------------
    initial begin : sequencer
        int n;
        // Clarke at the corners: both directions of alpha and beta clip.
        queue_word(CMD_CLARKE, 32767, -32768, -32768, 0, 1'b0);
        queue_word(CMD_CLARKE, -32768, 32767, 32767, 0, 1'b0);
        queue_word(CMD_CLARKE, 0, 32767, -32768, 0, 1'b0);
        queue_word(CMD_CLARKE, 0, -32768, 32767, 0, 1'b0);
        queue_word(CMD_CLARKE, 0, 0, 0, 65535, 1'b0);
        queue_word(CMD_CLARKE, 1, 0, 0, 0, 1'b0);
        // Park / inverse Park on the axes and at 45 degrees, where full-scale vectors clip.
        queue_word(CMD_PARK, 32767, 32767, 0, 0, 1'b0);
        queue_word(CMD_PARK, 32767, 32767, 0, 8192, 1'b0);
        queue_word(CMD_PARK, -32768, -32768, 0, 8192, 1'b0);
        queue_word(CMD_PARK, 32767, -32768, 0, 16384, 1'b0);
        queue_word(CMD_PARK, -32768, 32767, 0, 49152, 1'b0);
        queue_word(CMD_IPARK, 32767, 32767, -1, 40960, 1'b0);
        queue_word(CMD_IPARK, -32768, 32767, 0, 32768, 1'b0);
        queue_word(CMD_IPARK, -32768, -32768, 0, 24576, 1'b0);
        queue_word(CMD_IPARK, 12345, -23456, 0, 65535, 1'b0);
        // Sector at both ends of the angle range and either side of a boundary.
        queue_word(CMD_SECTOR, 32767, -32768, 32767, 0, 1'b0);
        queue_word(CMD_SECTOR, 0, 0, 0, 65535, 1'b0);
        queue_word(CMD_SECTOR, 0, 0, 0, 10922, 1'b0);
        queue_word(CMD_SECTOR, 0, 0, 0, 10923, 1'b0);
        queue_word(CMD_SECTOR, 0, 0, 0, 32768, 1'b0);
        queue_word(CMD_SECTOR, 0, 0, 0, 54613, 1'b0);

        // Random part; the sender empties the pipe before its first word and once later on.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            queue_word(t_cmd'($urandom_range(0, 3)), pick_q15(), pick_q15(), pick_q15(),
                       pick_angle(), (n == 0) || (n == 450));
        end

        // Synchronous reset, released on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        do @(posedge i_clk); while (pending_words.size() != 0 || i_valid);
        while (expected_results.size() != 0) @(posedge i_clk);
        // Watch a little longer for stray result words.
        repeat (12) @(posedge i_clk);

        $display("Checked %0d result words: %0d Clarke, %0d Park, %0d inverse Park, %0d sector",
                 results_checked, per_cmd[CMD_CLARKE], per_cmd[CMD_PARK],
                 per_cmd[CMD_IPARK], per_cmd[CMD_SECTOR]);
        $display("%0d of them clipped; %0d words sent in %0d cycles, %0d field errors",
                 sat_seen, words_accepted, cycle_count, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
